// ===== rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Command and status bundles between controller and datapath, field widths,
// register indexes and reset values.
// ----------------------------------------------------------------------------
package bb3_pkg;

   // Field widths that are fixed by the interface.
   localparam int PIX_W    = 8;
   localparam int FW_W     = 11;
   localparam int FH_W     = 13;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   // Neighbourhood sums and the rounding division.
   localparam int SUM_W     = 12;
   localparam int NUM_W     = SUM_W + 1;
   localparam int DEN_W     = 5;
   localparam int TCNT_W    = 4;
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W    = 4;

   // Register indexes.
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // Register reset values.
   localparam int RST_WIDTH  = 640;
   localparam int RST_HEIGHT = 480;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic latch;
      logic mult;
      logic write;
      logic tap_clear;
      logic tap_issue;
      logic tap_acc;
      logic div_load;
      logic div_step;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit_due;
      logic tap_last;
      logic div_last;
   } sts_type;

endpackage

// ===== rtl/box_blur_3x3_stream.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_stream: streaming 3x3 box blur of RGB pixels
// An item that releases a result passes size latch, total, ring write, decide,
// the tap walk and the division before it is shown; one that releases none
// frees the block after the decide state. One item at a time, set by the nine
// single-port ring tap reads, the 13-step divider and output stalls.
// Reset is synchronous; it clears the state, frame size and position counters, not the ring.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [bb3_pkg::PIX_W-1:0]  req_in_red,
   input  logic [bb3_pkg::PIX_W-1:0]  req_in_green,
   input  logic [bb3_pkg::PIX_W-1:0]  req_in_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bb3_pkg::PIX_W-1:0]  rsp_out_red,
   output logic [bb3_pkg::PIX_W-1:0]  rsp_out_green,
   output logic [bb3_pkg::PIX_W-1:0]  rsp_out_blue,
   output logic                       rsp_frame_end,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [bb3_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bb3_pkg::CSR_W-1:0]  csr_pwdata,
   output logic [bb3_pkg::CSR_W-1:0]  csr_prdata,
   output logic                       csr_pready
);
   import bb3_pkg::*;

   cmd_type         cmd;
   sts_type         sts;
   logic [FW_W-1:0] fw_ff;
   logic [FH_W-1:0] fh_ff;
   logic            csr_idx;
   logic            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FW_W'(RST_WIDTH);
         fh_ff <= FH_W'(RST_HEIGHT);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FRAME_WIDTH:  fw_ff <= csr_pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: fh_ff <= csr_pwdata[FH_W-1:0];
            default:          fw_ff <= fw_ff;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_idx)
         REG_FRAME_WIDTH:  csr_prdata = CSR_W'(fw_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_W'(fh_ff);
         default:          csr_prdata = '0;
      endcase
   end

   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bb3_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_func      (req_func),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .frame_width   (fw_ff),
      .frame_height  (fh_ff),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end)
   );

   // A result never waits while a new item is being taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result pending while input is ready");

   // An accepted item cannot release its result in the next cycle.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result shown straight after an accepted item");

   // The divider only runs after the tap walk and never while a result waits.
   a_div_not_in_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !cmd.div_step && !cmd.tap_acc)
      else $error("datapath busy while a result is shown");

endmodule

// ===== rtl/bb3_ctrl.sv =====
// ----------------------------------------------------------------------------
// bb3_ctrl: sequencer of the 3x3 box blur
// Steps one item through size latch, total, line store write and, when a result
// is due, the nine tap reads, the rounding division and the result handshake.
// ----------------------------------------------------------------------------
module bb3_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bb3_pkg::cmd_type cmd,
   input  bb3_pkg::sts_type sts
);
   import bb3_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LATCH  = 4'd1;
   localparam logic [3:0] ST_TOTAL  = 4'd2;
   localparam logic [3:0] ST_WRITE  = 4'd3;
   localparam logic [3:0] ST_DECIDE = 4'd4;
   localparam logic [3:0] ST_TADDR  = 4'd5;
   localparam logic [3:0] ST_TACC   = 4'd6;
   localparam logic [3:0] ST_DINIT  = 4'd7;
   localparam logic [3:0] ST_DIV    = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LATCH;
            end
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            state_in  = ST_TOTAL;
         end
         ST_TOTAL: begin
            cmd.mult = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.tap_clear = 1'b1;
            state_in      = sts.emit_due ? ST_TADDR : ST_IDLE;
         end
         ST_TADDR: begin
            cmd.tap_issue = 1'b1;
            state_in      = ST_TACC;
         end
         ST_TACC: begin
            cmd.tap_acc = 1'b1;
            state_in    = sts.tap_last ? ST_DINIT : ST_TADDR;
         end
         ST_DINIT: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/bb3_datapath.sv =====
// ----------------------------------------------------------------------------
// bb3_datapath: counters, pixel ring, tap accumulator and divider
// Holds the recent pixels in a ring memory, sums the in-frame taps of the
// next result one at a time and forms the rounded mean by restoring division.
// ----------------------------------------------------------------------------
module bb3_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bb3_pkg::cmd_type           cmd,
   output bb3_pkg::sts_type           sts,
   input  logic                       req_func,
   input  logic [bb3_pkg::PIX_W-1:0]  req_in_red,
   input  logic [bb3_pkg::PIX_W-1:0]  req_in_green,
   input  logic [bb3_pkg::PIX_W-1:0]  req_in_blue,
   input  logic [bb3_pkg::FW_W-1:0]   frame_width,
   input  logic [bb3_pkg::FH_W-1:0]   frame_height,
   output logic [bb3_pkg::PIX_W-1:0]  rsp_out_red,
   output logic [bb3_pkg::PIX_W-1:0]  rsp_out_green,
   output logic [bb3_pkg::PIX_W-1:0]  rsp_out_blue,
   output logic                       rsp_frame_end
);
   import bb3_pkg::*;

   function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] m);
      logic [31:0] r;
      r = v;
      if (v == 32'd0) begin
         r = 32'd1;
      end else if (v > m) begin
         r = m;
      end
      return r;
   endfunction

   localparam int W_W   = $clog2(MAX_WIDTH + 1);
   localparam int H_W   = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int RING  = 2 * MAX_WIDTH + 4;
   localparam int AW    = $clog2(RING);
   localparam int RST_W = (RST_WIDTH < MAX_WIDTH) ? RST_WIDTH : MAX_WIDTH;
   localparam int RST_H = (RST_HEIGHT < MAX_HEIGHT) ? RST_HEIGHT : MAX_HEIGHT;
   localparam logic signed [AW+1:0] RING_S = (AW+2)'(RING);
   localparam int PX_W  = 3 * PIX_W;

   // Captured item.
   logic            func_ff;
   logic [PX_W-1:0] pix_ff;

   // Frame size and counters.
   logic [W_W-1:0]   actw_ff;
   logic [H_W-1:0]   acth_ff;
   logic [CNT_W-1:0] total_ff;
   logic [CNT_W-1:0] rcv_ff;
   logic [CNT_W-1:0] e_ff;
   logic [AW-1:0]    wptr_ff;
   logic [AW-1:0]    eptr_ff;
   logic [H_W-1:0]   er_ff;
   logic [W_W-1:0]   ec_ff;

   // Tap walk and sums.
   logic [1:0]        ri_ff;
   logic [1:0]        ci_ff;
   logic              tapok_ff;
   logic [PX_W-1:0]   rd_ff;
   logic [SUM_W-1:0]  sum_r_ff, sum_g_ff, sum_b_ff;
   logic [TCNT_W-1:0] cnt_ff;

   // Divider.
   logic [NUM_W-1:0]  num_r_ff, num_g_ff, num_b_ff;
   logic [DEN_W-1:0]  rem_r_ff, rem_g_ff, rem_b_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff;

   logic [PX_W-1:0] ring_mem [RING];

   logic                wr_en;
   logic                tap_in;
   logic                row_ok, col_ok;
   logic signed [AW+1:0] taddr_raw;
   logic signed [AW+1:0] row_off;
   logic signed [AW+1:0] col_off;
   logic [AW-1:0]       taddr;
   logic [CNT_W:0]      e_next;
   logic                last_pix;

   assign wr_en    = cmd.write && !func_ff && (rcv_ff < total_ff);
   assign e_next   = {1'b0, e_ff} + (CNT_W+1)'(1);
   assign last_pix = (e_next == {1'b0, total_ff});

   // Emission rule: enough pixels are ahead of the next result, or the frame is in.
   assign sts.emit_due = (e_ff < rcv_ff) &&
      (({1'b0, rcv_ff} >= e_next + (CNT_W+1)'(actw_ff) + (CNT_W+1)'(1)) ||
       (rcv_ff == total_ff));
   assign sts.tap_last = (ri_ff == 2'd2) && (ci_ff == 2'd2);
   assign sts.div_last = (step_ff == STEP_W'(DIV_STEPS - 1));

   // In-frame test for the current tap.
   always_comb begin
      row_ok = 1'b1;
      col_ok = 1'b1;
      if (ri_ff == 2'd0) begin
         row_ok = (er_ff != '0);
      end else if (ri_ff == 2'd2) begin
         row_ok = ({1'b0, er_ff} + (H_W+1)'(1)) < {1'b0, acth_ff};
      end
      if (ci_ff == 2'd0) begin
         col_ok = (ec_ff != '0);
      end else if (ci_ff == 2'd2) begin
         col_ok = ({1'b0, ec_ff} + (W_W+1)'(1)) < {1'b0, actw_ff};
      end
      tap_in = row_ok && col_ok;
   end

   // Ring address of the current tap, wrapped once.
   always_comb begin
      case (ri_ff)
         2'd0:    row_off = -$signed((AW+2)'(actw_ff));
         2'd2:    row_off = $signed((AW+2)'(actw_ff));
         default: row_off = '0;
      endcase
      case (ci_ff)
         2'd0:    col_off = -(AW+2)'(1);
         2'd2:    col_off = (AW+2)'(1);
         default: col_off = '0;
      endcase
      taddr_raw = $signed({2'b00, eptr_ff}) + row_off + col_off;
      if (taddr_raw < 0) begin
         taddr_raw = taddr_raw + RING_S;
      end else if (taddr_raw >= RING_S) begin
         taddr_raw = taddr_raw - RING_S;
      end
      taddr = taddr_raw[AW-1:0];
   end

   // Pixel ring: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wptr_ff] <= pix_ff;
      end
      if (cmd.tap_issue) begin
         rd_ff    <= ring_mem[taddr];
         tapok_ff <= tap_in;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         pix_ff  <= {req_in_red, req_in_green, req_in_blue};
      end
   end

   // Frame size and position counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         actw_ff  <= W_W'(RST_W);
         acth_ff  <= H_W'(RST_H);
         total_ff <= CNT_W'(RST_W * RST_H);
         rcv_ff   <= '0;
         e_ff     <= '0;
         wptr_ff  <= '0;
         eptr_ff  <= '0;
         er_ff    <= '0;
         ec_ff    <= '0;
      end else begin
         if (cmd.latch && !func_ff && rcv_ff == '0 && e_ff == '0) begin
            actw_ff <= W_W'(clamp_dim(32'(frame_width), 32'(MAX_WIDTH)));
            acth_ff <= H_W'(clamp_dim(32'(frame_height), 32'(MAX_HEIGHT)));
         end
         if (cmd.mult) begin
            total_ff <= CNT_W'(actw_ff) * CNT_W'(acth_ff);
         end
         if (wr_en) begin
            rcv_ff  <= rcv_ff + CNT_W'(1);
            wptr_ff <= (wptr_ff == AW'(RING - 1)) ? '0 : wptr_ff + AW'(1);
         end
         if (cmd.emit) begin
            if (last_pix) begin
               rcv_ff  <= '0;
               e_ff    <= '0;
               wptr_ff <= '0;
               eptr_ff <= '0;
               er_ff   <= '0;
               ec_ff   <= '0;
            end else begin
               e_ff    <= e_next[CNT_W-1:0];
               eptr_ff <= (eptr_ff == AW'(RING - 1)) ? '0 : eptr_ff + AW'(1);
               if (({1'b0, ec_ff} + (W_W+1)'(1)) == {1'b0, actw_ff}) begin
                  ec_ff <= '0;
                  er_ff <= er_ff + H_W'(1);
               end else begin
                  ec_ff <= ec_ff + W_W'(1);
               end
            end
         end
      end
   end

   // Tap walk and accumulation.
   always_ff @(posedge clock) begin
      if (cmd.tap_clear) begin
         ri_ff    <= '0;
         ci_ff    <= '0;
         sum_r_ff <= '0;
         sum_g_ff <= '0;
         sum_b_ff <= '0;
         cnt_ff   <= '0;
      end else if (cmd.tap_acc) begin
         if (tapok_ff) begin
            sum_r_ff <= sum_r_ff + SUM_W'(rd_ff[3*PIX_W-1:2*PIX_W]);
            sum_g_ff <= sum_g_ff + SUM_W'(rd_ff[2*PIX_W-1:PIX_W]);
            sum_b_ff <= sum_b_ff + SUM_W'(rd_ff[PIX_W-1:0]);
            cnt_ff   <= cnt_ff + TCNT_W'(1);
         end
         if (ci_ff == 2'd2) begin
            ci_ff <= '0;
            ri_ff <= ri_ff + 2'd1;
         end else begin
            ci_ff <= ci_ff + 2'd1;
         end
      end
   end

   // Restoring division of (2*sum+count) by 2*count, one bit a cycle.
   function automatic logic [DEN_W+NUM_W-1:0] div_bit(input logic [DEN_W-1:0] rem,
                                                      input logic [NUM_W-1:0] num,
                                                      input logic [DEN_W-1:0] den);
      logic [DEN_W:0]   trial;
      logic [DEN_W-1:0] rem_o;
      logic             q;
      trial = {rem, num[NUM_W-1]};
      q     = (trial >= {1'b0, den});
      rem_o = q ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      return {rem_o, num[NUM_W-2:0], q};
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_r_ff <= {sum_r_ff, 1'b0} + NUM_W'(cnt_ff);
         num_g_ff <= {sum_g_ff, 1'b0} + NUM_W'(cnt_ff);
         num_b_ff <= {sum_b_ff, 1'b0} + NUM_W'(cnt_ff);
         den_ff   <= {cnt_ff, 1'b0};
         rem_r_ff <= '0;
         rem_g_ff <= '0;
         rem_b_ff <= '0;
         step_ff  <= '0;
      end else if (cmd.div_step) begin
         {rem_r_ff, num_r_ff} <= div_bit(rem_r_ff, num_r_ff, den_ff);
         {rem_g_ff, num_g_ff} <= div_bit(rem_g_ff, num_g_ff, den_ff);
         {rem_b_ff, num_b_ff} <= div_bit(rem_b_ff, num_b_ff, den_ff);
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   assign rsp_out_red   = num_r_ff[PIX_W-1:0];
   assign rsp_out_green = num_g_ff[PIX_W-1:0];
   assign rsp_out_blue  = num_b_ff[PIX_W-1:0];
   assign rsp_frame_end = last_pix;

endmodule
